FILE: sv/matrix_add_multiply_transpose_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the matrix add / multiply / transpose block.
// Both macros expect signals named clk and rst in the scope of use.
// ---------------------------------------------------------------------------
`ifndef MATRIX_ADD_MULTIPLY_TRANSPOSE_ASSERT_SVH
`define MATRIX_ADD_MULTIPLY_TRANSPOSE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MAMT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mamt: same-cycle check failed");
// Next-cycle implication.
`define MAMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mamt: next-cycle check failed");
`else
`define MAMT_ASSERT_IMP(label, ante, cons)
`define MAMT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: sv/mamt_pkg.sv
// ---------------------------------------------------------------------------
// mamt_pkg
// Shared types, codes and the microcode table of the matrix engine.
// ---------------------------------------------------------------------------
package mamt_pkg;

  localparam int DATA_W = 32;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_COLS = 2'd2;

  // Operation codes
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_MUL = 2'd1;
  localparam logic [1:0] MODE_TR  = 2'd2;

  // Sequencer steps
  localparam logic [1:0] STEP_IDLE  = 2'd0;
  localparam logic [1:0] STEP_RUN   = 2'd1;
  localparam logic [1:0] STEP_WRAP  = 2'd2;
  localparam logic [1:0] STEP_SPARE = 2'd3;

  // Counter operations
  localparam logic [1:0] CNT_HOLD  = 2'd0;
  localparam logic [1:0] CNT_CLEAR = 2'd1;
  localparam logic [1:0] CNT_STEP  = 2'd2;

  // Jump conditions
  localparam logic [1:0] COND_NEVER    = 2'd0;
  localparam logic [1:0] COND_ALWAYS   = 2'd1;
  localparam logic [1:0] COND_NO_START = 2'd2;
  localparam logic [1:0] COND_NOT_DONE = 2'd3;

  typedef struct packed {
    logic       load;
    logic       issue;
    logic [1:0] cnt_op;
    logic [1:0] cond;
    logic [1:0] target;
  } mamt_uword_t;

  // Flags that travel with each memory read down the pipeline.
  typedef struct packed {
    logic issue;
    logic first;
    logic last_t;
    logic eor;
    logic final_res;
  } mamt_tag_t;

  function automatic mamt_uword_t mamt_rom(input logic [1:0] pc);
    mamt_uword_t w;
    unique case (pc)
      STEP_IDLE: w = '{load: 1'b1, issue: 1'b0, cnt_op: CNT_CLEAR,
                       cond: COND_NO_START, target: STEP_IDLE};
      STEP_RUN:  w = '{load: 1'b0, issue: 1'b1, cnt_op: CNT_STEP,
                       cond: COND_NOT_DONE, target: STEP_RUN};
      STEP_WRAP: w = '{load: 1'b0, issue: 1'b0, cnt_op: CNT_CLEAR,
                       cond: COND_ALWAYS, target: STEP_IDLE};
      default:   w = '{load: 1'b0, issue: 1'b0, cnt_op: CNT_HOLD,
                       cond: COND_ALWAYS, target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Zero counts as one, anything above the maximum as the maximum.
  function automatic logic [3:0] mamt_clamp(input logic [3:0] d, input logic [3:0] dmax);
    logic [3:0] r;
    if (d == 4'd0) r = 4'd1;
    else if (d > dmax) r = dmax;
    else r = d;
    return r;
  endfunction

endpackage

FILE: sv/mamt_sequencer.sv
// ---------------------------------------------------------------------------
// mamt_sequencer
// Step counter over the microcode table, loop counters, address generation
// and the load counter that steers incoming items into the two stores.
// ---------------------------------------------------------------------------
`include "matrix_add_multiply_transpose_assert.svh"

module mamt_sequencer import mamt_pkg::*; #(
  parameter int MAX_DIM = 8,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int AW = $clog2(DEPTH),
  localparam int IW = $clog2(MAX_DIM),
  localparam int SW = $clog2(DEPTH + 1),
  localparam int CW = AW + 1,
  localparam int TW = AW + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_clear,
  input  logic          is_mul,
  input  logic          is_tr,
  input  logic [IW-1:0] r_m1,
  input  logic [IW-1:0] c_m1,
  input  logic [SW-1:0] size,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          stall,
  output logic          wr_en,
  output logic          wr_sel_b,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_addr_a,
  output logic [AW-1:0] rd_addr_b,
  output mamt_tag_t     tag
);

  logic [1:0]    pc;
  logic [1:0]    pc_next;
  mamt_uword_t   uc;
  logic          step_en;
  logic          cond_true;

  logic [IW-1:0] i, j, t;
  logic [AW-1:0] ib, jb, tb;
  logic [IW-1:0] i_lim, j_lim, t_lim;
  logic          i_last, j_last, t_last, all_last;
  logic [AW-1:0] r_step, c_step;

  logic [CW-1:0] load_count;
  logic [CW-1:0] b_off;
  logic [TW-1:0] total;
  logic          in_fire, load_last, load_done, in_a;

  assign uc = mamt_rom(pc);

  // Loading
  assign in_ready  = uc.load;
  assign in_fire   = in_valid & in_ready;
  assign total     = is_tr ? TW'(size) : (TW'(size) << 1);
  assign load_last = (TW'(load_count) + TW'(1)) >= total;
  assign load_done = in_fire & load_last;
  assign in_a      = load_count < CW'(size);
  assign b_off     = load_count - CW'(size);
  assign wr_en     = in_fire;
  assign wr_sel_b  = ~in_a;
  assign wr_addr   = in_a ? load_count[AW-1:0] : b_off[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (cfg_clear) begin
      load_count <= '0;
    end else if (in_fire) begin
      load_count <= load_last ? '0 : load_count + CW'(1);
    end
  end

  // Loop limits: the result runs i by j, each entry summing over t.
  assign i_lim    = is_tr ? c_m1 : r_m1;
  assign j_lim    = is_tr ? r_m1 : c_m1;
  assign t_lim    = is_mul ? r_m1 : '0;
  assign i_last   = (i == i_lim);
  assign j_last   = (j == j_lim);
  assign t_last   = (t == t_lim);
  assign all_last = i_last & j_last & t_last;
  assign r_step   = AW'(r_m1) + AW'(1);
  assign c_step   = AW'(c_m1) + AW'(1);

  // A step that reads the stores waits while the output side is stalled.
  assign step_en = ~(uc.issue & stall);

  always_comb begin
    case (uc.cond)
      COND_NEVER:    cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_NO_START: cond_true = ~load_done;
      COND_NOT_DONE: cond_true = ~all_last;
    endcase
    pc_next = cond_true ? uc.target : pc + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else if (step_en) begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i  <= '0;
      j  <= '0;
      t  <= '0;
      ib <= '0;
      jb <= '0;
      tb <= '0;
    end else if (step_en) begin
      case (uc.cnt_op)
        CNT_CLEAR: begin
          i  <= '0;
          j  <= '0;
          t  <= '0;
          ib <= '0;
          jb <= '0;
          tb <= '0;
        end
        CNT_STEP: begin
          if (t_last) begin
            t  <= '0;
            tb <= '0;
            if (j_last) begin
              j  <= '0;
              jb <= '0;
              if (i_last) begin
                i  <= '0;
                ib <= '0;
              end else begin
                i  <= i + IW'(1);
                ib <= ib + c_step;
              end
            end else begin
              j  <= j + IW'(1);
              jb <= jb + c_step;
            end
          end else begin
            t  <= t + IW'(1);
            tb <= tb + r_step;
          end
        end
        default: ;
      endcase
    end
  end

  // The base registers hold i*cols, j*cols and t*rows.
  always_comb begin
    if (is_tr) rd_addr_a = jb + AW'(i);
    else if (is_mul) rd_addr_a = ib + AW'(t);
    else rd_addr_a = ib + AW'(j);
    rd_addr_b = is_mul ? tb + AW'(j) : ib + AW'(j);
  end

  assign tag.issue     = uc.issue & ~stall;
  assign tag.first     = (t == '0);
  assign tag.last_t    = t_last;
  assign tag.eor       = j_last;
  assign tag.final_res = i_last & j_last;

  `MAMT_ASSERT_NEXT(a_start_runs, load_done, pc == STEP_RUN)
  `MAMT_ASSERT_NEXT(a_cfg_clears_load, cfg_clear, load_count == '0)
  `MAMT_ASSERT_NEXT(a_run_ends, uc.issue && !stall && all_last, pc == STEP_WRAP)

endmodule

FILE: sv/mamt_datapath.sv
// ---------------------------------------------------------------------------
// mamt_datapath
// Operand stores, the add / multiply stage, the accumulator and the output
// register.
// ---------------------------------------------------------------------------
`include "matrix_add_multiply_transpose_assert.svh"

module mamt_datapath import mamt_pkg::*; #(
  parameter int MAX_DIM = 8,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              is_mul,
  input  logic              is_tr,
  input  logic              wr_en,
  input  logic              wr_sel_b,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  input  mamt_tag_t         tag,
  output logic              stall,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data,
  output logic              out_eor,
  output logic              out_last
);

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];
  logic [DATA_W-1:0] rd_a, rd_b;
  logic [DATA_W-1:0] fn;
  logic [DATA_W-1:0] s2_val;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] sum;
  mamt_tag_t         s1_tag, s2_tag;
  logic              emit;

  // The whole pipeline freezes while a result waits to be taken.
  assign stall = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (wr_en && !wr_sel_b) mem_a[wr_addr] <= wr_data;
    if (!stall) rd_a <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_sel_b) mem_b[wr_addr] <= wr_data;
    if (!stall) rd_b <= mem_b[rd_addr_b];
  end

  // Only the low half of the product is kept: sums wrap modulo 2^32.
  always_comb begin
    if (is_mul) fn = rd_a * rd_b;
    else if (is_tr) fn = rd_a;
    else fn = rd_a + rd_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
    end else if (!stall) begin
      s1_tag <= tag;
      s2_tag <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) s2_val <= fn;
  end

  assign sum  = (s2_tag.first ? '0 : acc) + s2_val;
  assign emit = ~stall & s2_tag.issue & s2_tag.last_t;

  always_ff @(posedge clk) begin
    if (!stall && s2_tag.issue) acc <= sum;
    if (emit) begin
      out_data <= sum;
      out_eor  <= s2_tag.eor;
      out_last <= s2_tag.final_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `MAMT_ASSERT_IMP(a_last_ends_row, out_valid && out_last, out_eor)
  `MAMT_ASSERT_NEXT(a_stall_freezes, stall, $stable(s2_tag))
  `MAMT_ASSERT_NEXT(a_emit_shows, emit, out_valid)

endmodule

FILE: sv/matrix_add_multiply_transpose.sv
// ---------------------------------------------------------------------------
// matrix_add_multiply_transpose
// Integer matrix engine: elementwise add, square multiply or transpose.
// ---------------------------------------------------------------------------
// Configuration is written on the cfg channel (index 0 mode, 1 rows, 2 cols);
// any write to a known register drops a partly loaded matrix. The s channel
// takes elements row-major, A and then, for add and multiply, B, one item
// per cycle whenever the block is loading. After the final element the
// sequencer runs one read a cycle over the result loop, bar stalls: rows*cols
// reads for add and transpose, rows^3 multiply-accumulates for multiply. A
// result passes the read, operand stage and output registers; results come
// one a cycle for add and transpose, one per rows reads for multiply, bar
// stalls; m_tuser marks the end of each result row and m_tlast the final
// result. A wrap-up step follows before the next load begins, and a new load
// may proceed while the last results still drain. The run length is set by
// the single read port of each operand store. While the receiver stalls, the
// result pipeline and the compute loop freeze with nothing lost. Reset
// returns the registers to add, 1 by 1, and clears the load count; the stores
// are not cleared, as every entry read is written earlier in the same load.
// ---------------------------------------------------------------------------
`include "matrix_add_multiply_transpose_assert.svh"

module matrix_add_multiply_transpose import mamt_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [3:0]               cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic signed [DATA_W-1:0] s_tdata,  // element
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic signed [DATA_W-1:0] m_tdata,  // result_element
  output logic                     m_tuser,  // end_of_row
  output logic                     m_tlast   // last_result
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(MAX_DIM);
  localparam int SW = $clog2(DEPTH + 1);

  logic [1:0]        mode;
  logic [3:0]        rows;
  logic [3:0]        cols;
  logic              cfg_clear;
  logic              is_mul, is_tr;
  logic [3:0]        rows_c, cols_c, cols_eff;
  logic [7:0]        size_full;
  logic [IW-1:0]     r_m1, c_m1;
  logic              stall;
  logic              wr_en, wr_sel_b;
  logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
  mamt_tag_t         tag;
  logic [DATA_W-1:0] out_data;

  assign cfg_ready = 1'b1;
  assign cfg_clear = cfg_valid &
                     ((cfg_index == CFG_MODE) || (cfg_index == CFG_ROWS) ||
                      (cfg_index == CFG_COLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ADD;
      rows <= 4'd1;
      cols <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE: mode <= cfg_data[1:0];
        CFG_ROWS: rows <= cfg_data;
        CFG_COLS: cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // The spare mode code decodes as transpose.
  assign is_mul    = (mode == MODE_MUL);
  assign is_tr     = |(mode & MODE_TR);
  assign rows_c    = mamt_clamp(rows, 4'(MAX_DIM));
  assign cols_c    = mamt_clamp(cols, 4'(MAX_DIM));
  assign cols_eff  = is_mul ? rows_c : cols_c;
  assign size_full = rows_c * cols_eff;
  assign r_m1      = IW'(rows_c - 4'd1);
  assign c_m1      = IW'(cols_eff - 4'd1);

  mamt_sequencer #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_clear (cfg_clear),
    .is_mul    (is_mul),
    .is_tr     (is_tr),
    .r_m1      (r_m1),
    .c_m1      (c_m1),
    .size      (size_full[SW-1:0]),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .stall     (stall),
    .wr_en     (wr_en),
    .wr_sel_b  (wr_sel_b),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .tag       (tag)
  );

  mamt_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .is_mul    (is_mul),
    .is_tr     (is_tr),
    .wr_en     (wr_en),
    .wr_sel_b  (wr_sel_b),
    .wr_addr   (wr_addr),
    .wr_data   (s_tdata),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .tag       (tag),
    .stall     (stall),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data),
    .out_eor   (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = out_data;

  `MAMT_ASSERT_IMP(a_no_load_in_run, s_tvalid && s_tready, !tag.issue)
  `MAMT_ASSERT_IMP(a_dims_in_range, 1'b1, rows_c != 4'd0 && cols_c != 4'd0)
  `MAMT_ASSERT_NEXT(a_cfg_ready_kept, cfg_valid, cfg_ready)

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Matrix engine regression
// Drives element streams and register writes into the matrix add / multiply /
// transpose block and checks every result item against a predictor that
// keeps its own copy of both operand stores, the load count and the
// registers. Both stream sides idle at random, and the result side once holds
// off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import mamt_pkg::*;

localparam int DIM_LIMIT = 8;
localparam logic [1:0] CFG_UNUSED = 2'd3;
localparam logic [1:0] MODE_SPARE = 2'd3;

typedef struct packed {
  logic [DATA_W-1:0] value;
  logic              eor;
  logic              last;
} result_entry_t;

class matrix_scoreboard;
  logic [DATA_W-1:0] store_a [64];
  logic [DATA_W-1:0] store_b [64];
  int unsigned load_count;
  logic [1:0] mode;
  logic [3:0] rows;
  logic [3:0] cols;
  result_entry_t entries_due [$];
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned loads_done;
  int unsigned reg_writes;

  function new();
    load_count = 0;
    mode = MODE_ADD;
    rows = 4'd1;
    cols = 4'd1;
  endfunction

  function int unsigned clamp_dim(logic [3:0] d);
    if (d == 4'd0) return 1;
    if (d > DIM_LIMIT) return DIM_LIMIT;
    return d;
  endfunction

  // Number of elements that make up one complete load at the present setting.
  function int unsigned load_length();
    int unsigned r;
    int unsigned c;
    r = clamp_dim(rows);
    c = (mode == MODE_MUL) ? r : clamp_dim(cols);
    return mode[1] ? r * c : 2 * r * c;
  endfunction

  function void write_register(logic [1:0] index, logic [3:0] value);
    reg_writes++;
    case (index)
      CFG_MODE: mode = value[1:0];
      CFG_ROWS: rows = value;
      CFG_COLS: cols = value;
      default: return;
    endcase
    // Any write to a real register throws away a partial load.
    load_count = 0;
  endfunction

  function void push_entry(logic [DATA_W-1:0] value, bit eor, bit last);
    result_entry_t e;
    e.value = value;
    e.eor = eor;
    e.last = last;
    entries_due.push_back(e);
  endfunction

  function void accept_element(logic [DATA_W-1:0] elem);
    bit is_mul;
    bit is_tr;
    int unsigned r;
    int unsigned c;
    int unsigned size;
    logic [DATA_W-1:0] acc;
    is_mul = (mode == MODE_MUL);
    // Only the upper mode bit selects transpose, so the spare code behaves so too.
    is_tr = mode[1];
    r = clamp_dim(rows);
    c = is_mul ? r : clamp_dim(cols);
    size = r * c;
    if (load_count < size) store_a[load_count] = elem;
    else store_b[load_count - size] = elem;
    if (load_count + 1 < load_length()) begin
      load_count++;
      return;
    end
    load_count = 0;
    loads_done++;
    if (is_tr) begin
      for (int i = 0; i < c; i++)
        for (int j = 0; j < r; j++)
          push_entry(store_a[j * c + i], j == r - 1, i == c - 1 && j == r - 1);
    end else if (is_mul) begin
      for (int i = 0; i < r; i++)
        for (int j = 0; j < r; j++) begin
          acc = '0;
          for (int t = 0; t < r; t++)
            acc = acc + store_a[i * r + t] * store_b[t * r + j];
          push_entry(acc, j == r - 1, i == r - 1 && j == r - 1);
        end
    end else begin
      for (int i = 0; i < r; i++)
        for (int j = 0; j < c; j++)
          push_entry(store_a[i * c + j] + store_b[i * c + j], j == c - 1,
                     i == r - 1 && j == c - 1);
    end
  endfunction

  function int unsigned outstanding();
    return entries_due.size();
  endfunction

  function void report(string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at result %0d: %s", results_checked, what);
  endfunction

  function void check_entry(logic [DATA_W-1:0] value, logic eor, logic last);
    result_entry_t want;
    results_checked++;
    if (entries_due.size() == 0) begin
      report($sformatf("unexpected result %h eor %b last %b", value, eor, last));
      return;
    end
    want = entries_due.pop_front();
    if (value !== want.value) report($sformatf("value %h, wanted %h", value, want.value));
    if (eor !== want.eor) report($sformatf("end of row %b, wanted %b", eor, want.eor));
    if (last !== want.last) report($sformatf("last %b, wanted %b", last, want.last));
  endfunction
endclass

module testbench;
  localparam int RANDOM_ITEMS = 180;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_MODE;
  logic [3:0] cfg_data = 4'd0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic signed [DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic signed [DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  matrix_scoreboard sb = new();
  bit in_quiet;
  bit out_quiet;
  bit hold_request;
  int unsigned elements_sent;
  int unsigned partial_loads;
  int unsigned stall_cycles;

  matrix_add_multiply_transpose #(.MAX_DIM(DIM_LIMIT)) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results still due",
               stall_cycles, sb.outstanding());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_element(input logic [DATA_W-1:0] value);
    int gap;
    if ($urandom_range(0, 11) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.accept_element(value);
    elements_sent++;
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(index, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering elements until every due result is out, then let the
  // sequencer finish its wrap-up step before anything else happens.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [3:0] draw_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 4'd0;
    if (pick == 1) return 4'($urandom_range(4, 15));
    return 4'($urandom_range(1, 3));
  endfunction

  function automatic logic [DATA_W-1:0] draw_element();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 11) == 0) out_quiet = !out_quiet;
      gap = out_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_entry(m_tdata, m_tuser, m_tlast);
      if (hold_request) begin
        // Long hold-off so that the result pipeline backs up into the loader.
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int unsigned len;
    int unsigned nloads;
    int unsigned random_start;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting is a 1 by 1 add: largest positive plus one wraps round.
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0001);
    settle();

    // 2 by 2 multiply with the extreme values; cols must be ignored here.
    write_reg(CFG_MODE, {2'b00, MODE_MUL});
    write_reg(CFG_ROWS, 4'd2);
    write_reg(CFG_COLS, 4'd15);
    send_element(32'h8000_0000);
    send_element(32'hFFFF_FFFF);
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0001);
    send_element(32'hFFFF_FFFF);
    send_element(32'h7FFF_FFFF);
    send_element(32'h8000_0000);
    send_element(32'h0000_0002);
    settle();

    // Transpose with rows of zero counting as one and cols above the limit.
    write_reg(CFG_MODE, {2'b00, MODE_TR});
    write_reg(CFG_ROWS, 4'd0);
    write_reg(CFG_COLS, 4'd9);
    for (int k = 0; k < 8; k++) send_element(32'h1000_0000 * k + 32'hF);
    settle();

    // The spare mode code must behave as transpose; the input is 3 by 2.
    write_reg(CFG_MODE, {2'b10, MODE_SPARE});
    write_reg(CFG_ROWS, 4'd3);
    write_reg(CFG_COLS, 4'd2);
    for (int k = 0; k < 6; k++) send_element(32'hA5A5_0000 + k);
    settle();

    // A write to the unused index leaves a partial load intact, whereas a
    // write to a real register discards it.
    write_reg(CFG_MODE, {2'b11, MODE_ADD});
    write_reg(CFG_ROWS, 4'd1);
    write_reg(CFG_COLS, 4'd1);
    send_element(32'h0000_0005);
    settle();
    write_reg(CFG_UNUSED, 4'hF);
    send_element(32'hFFFF_FFF0);
    settle();
    send_element(32'h1234_5678);
    settle();
    write_reg(CFG_COLS, 4'd1);
    send_element(32'h8000_0000);
    send_element(32'h8000_0000);
    settle();

    random_start = elements_sent;
    phase = 0;
    // The first three phases always run, so the long hold-off is never skipped.
    while (phase < 3 || elements_sent - random_start < RANDOM_ITEMS) begin
      if (phase == 0) begin
        // Largest transpose: 8 by 8, rows given above the limit.
        write_reg(CFG_MODE, {2'b01, MODE_TR});
        write_reg(CFG_ROWS, 4'd15);
        write_reg(CFG_COLS, 4'd8);
      end else if (phase == 2) begin
        write_reg(CFG_MODE, {2'b00, MODE_ADD});
        write_reg(CFG_ROWS, 4'd2);
        write_reg(CFG_COLS, 4'd3);
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(CFG_MODE, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 3) != 0) write_reg(CFG_ROWS, draw_dim());
        if ($urandom_range(0, 3) != 0) write_reg(CFG_COLS, draw_dim());
        if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 4'($urandom_range(0, 15)));
      end
      len = sb.load_length();
      if (phase == 2) begin
        nloads = 4;
        hold_request = 1'b1;
      end else begin
        nloads = (len > 32) ? 1 : $urandom_range(1, 3);
      end
      repeat (nloads)
        for (int k = 0; k < len; k++) send_element(draw_element());
      // Now and then leave a load unfinished for the next write to discard.
      if (phase != 2 && len > 1 && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, len - 1)) send_element(draw_element());
        partial_loads++;
      end
      settle();
      phase++;
    end

    settle();
    $display("Run covered %0d elements in %0d complete loads and %0d partial ones, %0d phases,",
             elements_sent, sb.loads_done, partial_loads, phase);
    $display("%0d register writes and %0d result items checked.",
             sb.reg_writes, sb.results_checked);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
